[src/psd_pkg.sv]
package psd_pkg;

    // Widths fixed by the register map and the result format
    localparam int THR_BITS        = 20;
    localparam int APB_DATA_BITS   = 32;
    localparam int APB_ADDR_BITS   = 5;
    localparam int REG_IDX_BITS    = 3;

    // Default parameter values
    localparam int SCALE_FRAC_BITS_DEF = 16;
    localparam int DIST_BITS_DEF       = 21;

    // Register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_SELF_WARN  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_SELF_STOP  = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_SCENE_WARN = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_SCENE_STOP = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_SCENE_EN   = 3'd4;

    // Register reset values
    localparam logic [THR_BITS-1:0] WARN_RESET = 20'd100000;
    localparam logic [THR_BITS-1:0] STOP_RESET = 20'd50000;

    // Decision codes
    localparam logic [1:0] DEC_STOPPED  = 2'd0;
    localparam logic [1:0] DEC_FUTURE   = 2'd1;
    localparam logic [1:0] DEC_CUR_WARN = 2'd2;
    localparam logic [1:0] DEC_CLEAR    = 2'd3;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLASS,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

[src/proximity_speed_scale_decider_top.sv]
// Channel     Direction  Signals                                   Accepted when
// record      in         i_valid/o_ready, i_pose .. i_last_record  i_valid && o_ready
// result      out        o_valid/i_ready, o_scale_q16 .. fault     o_valid && i_ready
// config      in         APB psel/penable/pwrite/paddr/pwdata      psel && penable && pwrite
//
// An ordinary record is accepted while idle and the next may follow at once.
// A last record starts the sequencer: 4 class steps, each followed, for a ramping class,
// by SCALE_FRAC_BITS + 1 steps of the shared restoring divider, then the result load.
// The radix-2 divider gives one quotient bit per cycle.
// Reset is synchronous and active low; it restores the configuration registers and clears all classes.
// A stalled result holds the sequencer in its final state until taken.
module proximity_speed_scale_decider_top #(
    parameter int SCALE_FRAC_BITS = psd_pkg::SCALE_FRAC_BITS_DEF,
    parameter int DIST_BITS       = psd_pkg::DIST_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Record channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_pose,
    input  logic                                 i_kind,
    input  logic signed [DIST_BITS-1:0]          i_distance_um,
    input  logic                                 i_pair_empty,
    input  logic                                 i_last_record,
    // Result channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [SCALE_FRAC_BITS:0]             o_scale_q16,
    output logic [1:0]                           o_decision,
    output logic                                 o_config_fault,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [psd_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [psd_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [psd_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);

    localparam int SW  = SCALE_FRAC_BITS + 1;
    localparam int TB  = psd_pkg::THR_BITS;
    localparam int RW  = TB + 1;
    localparam int CW  = ((DIST_BITS > TB + 1) ? DIST_BITS : TB + 1) + 1;
    localparam int CNT_BITS = $clog2(SW);
    localparam logic [SW-1:0] SCALE_ONE = SW'(1) << SCALE_FRAC_BITS;
    localparam logic signed [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};

    // Configuration registers
    logic [TB-1:0] r_self_warn, r_self_stop, r_scene_warn, r_scene_stop;
    logic          r_scene_en;

    // Class accumulators, index = pose * 2 + kind
    logic signed [DIST_BITS-1:0] r_min [4];
    logic [3:0]                  r_seen;
    logic [3:0]                  r_forced;

    // Sequencer and shared divider
    psd_pkg::t_state r_state, n_state;
    logic [1:0]          r_idx;
    logic [RW-1:0]       r_rem;
    logic [TB-1:0]       r_span;
    logic [SW-1:0]       r_quo;
    logic [CNT_BITS-1:0] r_cnt;
    logic [SW-1:0]       r_cur, r_fut;

    // Output register
    logic                r_out_valid;
    logic [SW-1:0]       r_out_scale;
    logic [1:0]          r_out_dec;
    logic                r_out_fault;

    logic                      rec_accept;
    logic [1:0]                rec_idx;
    logic                      cfg_write;
    logic [psd_pkg::REG_IDX_BITS-1:0] cfg_idx;

    // APB handshake and register index
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[psd_pkg::APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        case (cfg_idx)
            psd_pkg::REG_SELF_WARN:  prdata = psd_pkg::APB_DATA_BITS'(r_self_warn);
            psd_pkg::REG_SELF_STOP:  prdata = psd_pkg::APB_DATA_BITS'(r_self_stop);
            psd_pkg::REG_SCENE_WARN: prdata = psd_pkg::APB_DATA_BITS'(r_scene_warn);
            psd_pkg::REG_SCENE_STOP: prdata = psd_pkg::APB_DATA_BITS'(r_scene_stop);
            psd_pkg::REG_SCENE_EN:   prdata = psd_pkg::APB_DATA_BITS'(r_scene_en);
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_warn  <= psd_pkg::WARN_RESET;
            r_self_stop  <= psd_pkg::STOP_RESET;
            r_scene_warn <= psd_pkg::WARN_RESET;
            r_scene_stop <= psd_pkg::STOP_RESET;
            r_scene_en   <= 1'b1;
        end else if (cfg_write) begin
            case (cfg_idx)
                psd_pkg::REG_SELF_WARN:  r_self_warn  <= pwdata[TB-1:0];
                psd_pkg::REG_SELF_STOP:  r_self_stop  <= pwdata[TB-1:0];
                psd_pkg::REG_SCENE_WARN: r_scene_warn <= pwdata[TB-1:0];
                psd_pkg::REG_SCENE_STOP: r_scene_stop <= pwdata[TB-1:0];
                psd_pkg::REG_SCENE_EN:   r_scene_en   <= pwdata[0];
                default: ;
            endcase
        end
    end

    assign rec_accept = i_valid && o_ready;
    assign rec_idx    = {i_pose, i_kind};

    // Thresholds and minimum of the class under evaluation
    logic [TB-1:0]          cls_warn, cls_stop;
    logic signed [CW-1:0]   d_ext, warn_ext, stop_ext, d_minus_stop;
    logic                   cls_skip, cls_start_div;
    logic [SW-1:0]          cls_trivial;
    logic                   div_bit;
    logic [RW-1:0]          div_rem_sub;
    logic [SW-1:0]          div_quo_next;
    logic                   fold_en;
    logic [SW-1:0]          fold_val;
    logic                   cfg_fault;
    logic [SW-1:0]          res_scale;
    logic [1:0]             res_dec;
    logic                   load_out;

    assign cls_warn = r_idx[0] ? r_scene_warn : r_self_warn;
    assign cls_stop = r_idx[0] ? r_scene_stop : r_self_stop;
    assign d_ext    = CW'(r_min[r_idx]);
    assign warn_ext = $signed({{(CW-TB){1'b0}}, cls_warn});
    assign stop_ext = $signed({{(CW-TB){1'b0}}, cls_stop});
    assign d_minus_stop = d_ext - stop_ext;

    // Class scale where no division is needed
    always_comb begin
        cls_skip      = r_idx[0] && !r_scene_en;
        cls_start_div = 1'b0;
        cls_trivial   = SCALE_ONE;
        if (r_forced[r_idx]) begin
            cls_trivial = '0;
        end else if (!r_seen[r_idx]) begin
            cls_trivial = SCALE_ONE;
        end else if (d_ext > warn_ext) begin
            cls_trivial = SCALE_ONE;
        end else if (d_ext <= stop_ext) begin
            cls_trivial = '0;
        end else begin
            cls_start_div = 1'b1;
        end
    end

    // One restoring division step: one quotient bit per cycle
    assign div_bit      = (r_rem >= {1'b0, r_span});
    assign div_rem_sub  = div_bit ? (r_rem - {1'b0, r_span}) : r_rem;
    assign div_quo_next = {r_quo[SW-2:0], div_bit};

    // Final decision between current and future pose
    assign cfg_fault = (r_self_warn <= r_self_stop) || (r_scene_warn <= r_scene_stop);

    always_comb begin
        if (cfg_fault) begin
            res_scale = '0;
            res_dec   = psd_pkg::DEC_STOPPED;
        end else if (r_cur < SCALE_ONE) begin
            if (r_cur == '0 && r_fut == '0) begin
                res_scale = '0;
                res_dec   = psd_pkg::DEC_STOPPED;
            end else if (r_cur >= r_fut) begin
                res_scale = r_fut;
                res_dec   = psd_pkg::DEC_FUTURE;
            end else begin
                res_scale = SCALE_ONE;
                res_dec   = psd_pkg::DEC_CUR_WARN;
            end
        end else if (r_fut < SCALE_ONE) begin
            res_scale = r_fut;
            res_dec   = psd_pkg::DEC_FUTURE;
        end else begin
            res_scale = SCALE_ONE;
            res_dec   = psd_pkg::DEC_CLEAR;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            psd_pkg::ST_IDLE: begin
                if (rec_accept && i_last_record) n_state = psd_pkg::ST_CLASS;
            end
            psd_pkg::ST_CLASS: begin
                if (!cls_skip && cls_start_div) n_state = psd_pkg::ST_DIV;
                else if (r_idx == 2'd3)         n_state = psd_pkg::ST_DONE;
            end
            psd_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = (r_idx == 2'd3) ? psd_pkg::ST_DONE : psd_pkg::ST_CLASS;
                end
            end
            psd_pkg::ST_DONE: begin
                if (!r_out_valid || i_ready) n_state = psd_pkg::ST_IDLE;
            end
            default: n_state = psd_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_ready  = 1'b0;
        fold_en  = 1'b0;
        fold_val = cls_trivial;
        load_out = 1'b0;
        case (r_state)
            psd_pkg::ST_IDLE: o_ready = 1'b1;
            psd_pkg::ST_CLASS: begin
                fold_en  = !cls_skip && !cls_start_div;
                fold_val = cls_trivial;
            end
            psd_pkg::ST_DIV: begin
                fold_en  = (r_cnt == '0);
                fold_val = div_quo_next;
            end
            psd_pkg::ST_DONE: load_out = !r_out_valid || i_ready;
            default: ;
        endcase
    end

    // Sequencer, divider and pose minima
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psd_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == psd_pkg::ST_IDLE) begin
                r_idx <= '0;
            end else if ((r_state == psd_pkg::ST_CLASS && (cls_skip || !cls_start_div)) ||
                         (r_state == psd_pkg::ST_DIV && r_cnt == '0)) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == psd_pkg::ST_IDLE) begin
            r_cur <= SCALE_ONE;
            r_fut <= SCALE_ONE;
        end else if (fold_en) begin
            if (!r_idx[1] && fold_val < r_cur) r_cur <= fold_val;
            if (r_idx[1] && fold_val < r_fut)  r_fut <= fold_val;
        end
        if (r_state == psd_pkg::ST_CLASS) begin
            r_rem  <= d_minus_stop[RW-1:0];
            r_span <= cls_warn - cls_stop;
            r_quo  <= '0;
            r_cnt  <= CNT_BITS'(SCALE_FRAC_BITS);
        end else if (r_state == psd_pkg::ST_DIV) begin
            r_rem <= {div_rem_sub[RW-2:0], 1'b0};
            r_quo <= div_quo_next;
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
    end

    // Class accumulators: updated per record, cleared once the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load_out) begin
            for (int k = 0; k < 4; k++) r_min[k] <= DIST_MAX;
            r_seen   <= '0;
            r_forced <= '0;
        end else if (rec_accept && (!i_kind || r_scene_en)) begin
            r_seen[rec_idx] <= 1'b1;
            if (i_pair_empty) begin
                r_forced[rec_idx] <= 1'b1;
            end else if (i_distance_um < r_min[rec_idx]) begin
                r_min[rec_idx] <= i_distance_um;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_scale <= res_scale;
            r_out_dec   <= res_dec;
            r_out_fault <= cfg_fault;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_scale_q16    = r_out_scale;
    assign o_decision     = r_out_dec;
    assign o_config_fault = r_out_fault;

    // A last record always starts the sequencer, which blocks further records.
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rec_accept && i_last_record) |=> !o_ready)
        else $error("record accepted while a decision was being computed");

    // A faulty configuration always gives a stop result.
    a_fault_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_config_fault) |-> (o_scale_q16 == '0 &&
                                         o_decision == psd_pkg::DEC_STOPPED))
        else $error("configuration fault without stop result");

    // The scale never exceeds 1.0.
    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_scale_q16 <= SCALE_ONE))
        else $error("scale above one");

    // Clear and current-warned decisions run at full speed.
    a_full_speed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_decision == psd_pkg::DEC_CLEAR ||
                     o_decision == psd_pkg::DEC_CUR_WARN)) |-> (o_scale_q16 == SCALE_ONE))
        else $error("full-speed decision with reduced scale");

endmodule
